>>> hdl/ahc_pkg.sv
// Shared types, register codes and elaboration-time tables for the affine Hill cipher.
// No dependencies; compiled first.
`default_nettype none

package ahc_pkg;

  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned LETTER_W     = 5;
  localparam int unsigned TBL_W        = 8;
  localparam int unsigned RED_ENTRIES  = 32;
  localparam int unsigned MAX_ALPHABET = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_TL  = 3'd0,
    CFG_KEY_TR  = 3'd1,
    CFG_KEY_BL  = 3'd2,
    CFG_KEY_BR  = 3'd3,
    CFG_DECRYPT = 3'd4
  } cfg_idx_t;

  typedef logic [LETTER_W-1:0]               letter_t;
  typedef logic [RED_ENTRIES*TBL_W-1:0]      red_tbl_t;
  typedef logic [MAX_ALPHABET*TBL_W-1:0]     inv_tbl_t;

  // residue of every 5-bit code modulo m
  function automatic red_tbl_t red_table(int unsigned m);
    red_tbl_t    tbl;
    int unsigned r;
    tbl = '0;
    r   = 0;
    for (int unsigned i = 0; i < RED_ENTRIES; i++) begin
      tbl[i*TBL_W +: TBL_W] = TBL_W'(r);
      r = r + 1;
      if (r == m) r = 0;
    end
    return tbl;
  endfunction

  // smallest inverse modulo m of every residue, zero where none exists
  function automatic inv_tbl_t inv_table(int unsigned m);
    inv_tbl_t    tbl;
    int unsigned acc;
    int unsigned found;
    tbl = '0;
    for (int unsigned a = 0; a < m; a++) begin
      acc   = 0;
      found = 0;
      for (int unsigned x = 1; x < m; x++) begin
        acc = acc + a;
        if (acc >= m) acc = acc - m;
        if (acc == 1 && found == 0) found = x;
      end
      tbl[a*TBL_W +: TBL_W] = TBL_W'(found);
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ahc_ifs.sv
// Request channels of the affine Hill cipher: letter pair in, result pair out.
// Depends on ahc_pkg.
`default_nettype none

interface ahc_in_if;
  import ahc_pkg::*;
  logic    valid;
  logic    ready;
  letter_t letter_first;
  letter_t letter_second;
  modport source (output valid, letter_first, letter_second, input ready);
  modport sink   (input valid, letter_first, letter_second, output ready);
endinterface

interface ahc_out_if;
  import ahc_pkg::*;
  logic    valid;
  logic    ready;
  letter_t out_first;
  letter_t out_second;
  logic    no_inverse;
  modport source (output valid, out_first, out_second, no_inverse, input ready);
  modport sink   (input valid, out_first, out_second, no_inverse, output ready);
endinterface

`default_nettype wire

>>> hdl/ahc_cfg.sv
// Configuration registers: key matrix entries stored already reduced, and the mode bit.
// Depends on ahc_pkg.
`default_nettype none

module ahc_cfg #(
  parameter int unsigned M  = 26,
  parameter int unsigned RW = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ahc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ahc_pkg::LETTER_W-1:0]   cfg_wdata,
  output logic [RW-1:0]                  key_tl,
  output logic [RW-1:0]                  key_tr,
  output logic [RW-1:0]                  key_bl,
  output logic [RW-1:0]                  key_br,
  output logic                           decrypt
);
  import ahc_pkg::*;

  localparam red_tbl_t      RED_TBL = red_table(M);
  localparam logic [RW-1:0] RST_TL  = RW'(RED_TBL[3*TBL_W +: TBL_W]);
  localparam logic [RW-1:0] RST_TR  = RW'(RED_TBL[3*TBL_W +: TBL_W]);
  localparam logic [RW-1:0] RST_BL  = RW'(RED_TBL[2*TBL_W +: TBL_W]);
  localparam logic [RW-1:0] RST_BR  = RW'(RED_TBL[5*TBL_W +: TBL_W]);

  logic [RW-1:0] key_tl_r, key_tr_r, key_bl_r, key_br_r;
  logic          decrypt_r;
  logic [RW-1:0] wred;

  assign wred = RW'(RED_TBL[cfg_wdata*TBL_W +: TBL_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_tl_r  <= RST_TL;
      key_tr_r  <= RST_TR;
      key_bl_r  <= RST_BL;
      key_br_r  <= RST_BR;
      decrypt_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_TL:  key_tl_r  <= wred;
        CFG_KEY_TR:  key_tr_r  <= wred;
        CFG_KEY_BL:  key_bl_r  <= wred;
        CFG_KEY_BR:  key_br_r  <= wred;
        CFG_DECRYPT: decrypt_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign key_tl  = key_tl_r;
  assign key_tr  = key_tr_r;
  assign key_bl  = key_bl_r;
  assign key_br  = key_br_r;
  assign decrypt = decrypt_r;

endmodule

`default_nettype wire

>>> hdl/ahc_modred.sv
// Three-stage reduction of an unsigned word modulo a constant by reciprocal multiply.
// Stand-alone; used by ahc_dec_key and the top level.
`default_nettype none

module ahc_modred #(
  parameter int unsigned M  = 26,
  parameter int unsigned W  = 11,
  parameter int unsigned RW = 5
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  x,
  output logic [RW-1:0] r
);

  localparam logic [W-1:0] RECIP = W'((64'd1 << W) / M);
  localparam logic [W-1:0] MOD_W = W'(M);
  localparam logic [RW:0]  MOD_R = (RW+1)'(M);

  logic [2*W-1:0] prod;
  logic [W-1:0]   x_r, q_r, diff;
  logic [RW:0]    rem_r;
  logic [RW-1:0]  r_r;

  assign prod = (2*W)'(x) * (2*W)'(RECIP);
  assign diff = x_r - W'(q_r * MOD_W);

  // quotient estimate is low by at most one, so one correction suffices
  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x;
      q_r   <= prod[2*W-1:W];
      rem_r <= (RW+1)'(diff);
      r_r   <= (rem_r >= MOD_R) ? RW'(rem_r - MOD_R) : RW'(rem_r);
    end
  end

  assign r = r_r;

endmodule

`default_nettype wire

>>> hdl/ahc_dec_key.sv
// Decryption matrix pipeline: determinant, inverse lookup, inverse times adjugate.
// Depends on ahc_pkg and ahc_modred; eleven stages.
`default_nettype none

module ahc_dec_key #(
  parameter int unsigned M  = 26,
  parameter int unsigned RW = 5,
  parameter int unsigned DW = 11
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] key_tl,
  input  logic [RW-1:0] key_tr,
  input  logic [RW-1:0] key_bl,
  input  logic [RW-1:0] key_br,
  output logic [RW-1:0] inv_00,
  output logic [RW-1:0] inv_01,
  output logic [RW-1:0] inv_10,
  output logic [RW-1:0] inv_11,
  output logic          no_inv
);
  import ahc_pkg::*;

  localparam inv_tbl_t      INV_TBL  = inv_table(M);
  localparam logic [DW-1:0] SQ       = DW'(M*M);
  localparam logic [RW:0]   MOD_R    = (RW+1)'(M);
  localparam int unsigned   FLAG_DLY = 5;

  logic [2*RW-1:0]     ad_r, bc_r;
  logic [DW-1:0]       detx_r;
  logic [RW-1:0]       det;
  logic [TBL_W-1:0]    inv_ent;
  logic [RW-1:0]       dinv_r;
  logic                ninv_r;
  logic [FLAG_DLY-1:0] ninv_pipe_r;
  logic [2*RW-1:0]     pa_r, pb_r, pc_r, pd_r;
  logic [RW-1:0]       red_a, red_b, red_c, red_d;
  logic [RW-1:0]       inv_00_r, inv_01_r, inv_10_r, inv_11_r;

  assign inv_ent = INV_TBL[det*TBL_W +: TBL_W];

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r        <= (2*RW)'(key_tl) * (2*RW)'(key_br);
      bc_r        <= (2*RW)'(key_tr) * (2*RW)'(key_bl);
      detx_r      <= DW'(ad_r) + SQ - DW'(bc_r);
      dinv_r      <= RW'(inv_ent);
      ninv_r      <= (inv_ent == '0);
      pa_r        <= (2*RW)'(key_tl) * (2*RW)'(dinv_r);
      pb_r        <= (2*RW)'(key_tr) * (2*RW)'(dinv_r);
      pc_r        <= (2*RW)'(key_bl) * (2*RW)'(dinv_r);
      pd_r        <= (2*RW)'(key_br) * (2*RW)'(dinv_r);
      ninv_pipe_r <= {ninv_pipe_r[FLAG_DLY-2:0], ninv_r};
      inv_00_r    <= red_d;
      inv_01_r    <= (red_b == '0) ? '0 : RW'(MOD_R - (RW+1)'(red_b));
      inv_10_r    <= (red_c == '0) ? '0 : RW'(MOD_R - (RW+1)'(red_c));
      inv_11_r    <= red_a;
    end
  end

  ahc_modred #(.M(M), .W(DW), .RW(RW)) u_det (
    .clk(clk), .en(en), .x(detx_r), .r(det)
  );
  ahc_modred #(.M(M), .W(2*RW), .RW(RW)) u_red_a (
    .clk(clk), .en(en), .x(pa_r), .r(red_a)
  );
  ahc_modred #(.M(M), .W(2*RW), .RW(RW)) u_red_b (
    .clk(clk), .en(en), .x(pb_r), .r(red_b)
  );
  ahc_modred #(.M(M), .W(2*RW), .RW(RW)) u_red_c (
    .clk(clk), .en(en), .x(pc_r), .r(red_c)
  );
  ahc_modred #(.M(M), .W(2*RW), .RW(RW)) u_red_d (
    .clk(clk), .en(en), .x(pd_r), .r(red_d)
  );

  assign inv_00 = inv_00_r;
  assign inv_01 = inv_01_r;
  assign inv_10 = inv_10_r;
  assign inv_11 = inv_11_r;
  assign no_inv = ninv_pipe_r[FLAG_DLY-1];

endmodule

`default_nettype wire

>>> hdl/affine_hill_cipher_2x2.sv
// Affine Hill cipher, 2x2 key, pipelined encrypt/decrypt of letter pairs.
// Throughput: one pair per cycle.
// The whole pipeline advances together; it holds while a finished result waits.
// Reset (synchronous, rst_n low) empties the pipeline and loads the default key, encrypt mode.
// Depends on ahc_pkg, ahc_ifs, ahc_cfg, ahc_modred, ahc_dec_key.
`default_nettype none

module affine_hill_cipher_2x2 #(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ahc_in_if.sink                        in_pair,
  ahc_out_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [ahc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ahc_pkg::LETTER_W-1:0]  cfg_wdata
);
  import ahc_pkg::*;

  localparam int unsigned RW      = $clog2(ALPHABET_SIZE);
  localparam int unsigned DW      = $clog2(2*ALPHABET_SIZE*ALPHABET_SIZE);
  localparam int unsigned KEY_LAT = 11;
  localparam int unsigned NS      = 18;
  localparam int unsigned FLAG_N  = NS - KEY_LAT;
  localparam red_tbl_t    RED_TBL = red_table(ALPHABET_SIZE);
  localparam logic [RW:0] MOD_R   = (RW+1)'(ALPHABET_SIZE);

  logic                en;
  logic [NS-1:0]       vld_r;
  logic [RW-1:0]       p0_pipe_r [KEY_LAT];
  logic [RW-1:0]       p1_pipe_r [KEY_LAT];

  logic [RW-1:0]       key_tl, key_tr, key_bl, key_br;
  logic                decrypt;
  logic [RW-1:0]       inv_00, inv_01, inv_10, inv_11;
  logic                no_inv;

  logic [RW:0]         v0_sum, v1_sum;
  logic [RW-1:0]       v0, v1;
  logic [RW-1:0]       m00_nxt, m01_nxt, m10_nxt, m11_nxt;
  logic [RW-1:0]       vec0_nxt, vec1_nxt, off0_nxt, off1_nxt;
  logic                flag_nxt;

  logic [RW-1:0]       m00_r, m01_r, m10_r, m11_r;
  logic [RW-1:0]       vec0_r, vec1_r, off0_r, off1_r, off0_d_r, off1_d_r;
  logic [FLAG_N-1:0]   flag_pipe_r;
  logic [2*RW-1:0]     pr00_r, pr01_r, pr10_r, pr11_r;
  logic [DW-1:0]       sum0_r, sum1_r;
  logic [RW-1:0]       r0, r1;
  letter_t             out_first_r, out_second_r;

  assign en            = !vld_r[NS-1] || out_res.ready;
  assign in_pair.ready = en;

  ahc_cfg #(.M(ALPHABET_SIZE), .RW(RW)) u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .key_tl(key_tl), .key_tr(key_tr), .key_bl(key_bl),
    .key_br(key_br), .decrypt(decrypt)
  );

  ahc_dec_key #(.M(ALPHABET_SIZE), .RW(RW), .DW(DW)) u_dec_key (
    .clk(clk), .en(en), .key_tl(key_tl), .key_tr(key_tr), .key_bl(key_bl),
    .key_br(key_br), .inv_00(inv_00), .inv_01(inv_01), .inv_10(inv_10),
    .inv_11(inv_11), .no_inv(no_inv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_pair.valid};
    end
  end

  // hold the reduced letters until the decryption matrix is ready
  always_ff @(posedge clk) begin
    if (en) begin
      p0_pipe_r[0] <= RW'(RED_TBL[in_pair.letter_first*TBL_W +: TBL_W]);
      p1_pipe_r[0] <= RW'(RED_TBL[in_pair.letter_second*TBL_W +: TBL_W]);
      for (int i = 1; i < KEY_LAT; i++) begin
        p0_pipe_r[i] <= p0_pipe_r[i-1];
        p1_pipe_r[i] <= p1_pipe_r[i-1];
      end
    end
  end

  always_comb begin
    v0_sum = (RW+1)'(p0_pipe_r[KEY_LAT-1]) + MOD_R - (RW+1)'(key_tl);
    v1_sum = (RW+1)'(p1_pipe_r[KEY_LAT-1]) + MOD_R - (RW+1)'(key_bl);
    v0     = (v0_sum >= MOD_R) ? RW'(v0_sum - MOD_R) : RW'(v0_sum);
    v1     = (v1_sum >= MOD_R) ? RW'(v1_sum - MOD_R) : RW'(v1_sum);
    if (decrypt) begin
      m00_nxt  = inv_00;
      m01_nxt  = inv_01;
      m10_nxt  = inv_10;
      m11_nxt  = inv_11;
      vec0_nxt = v0;
      vec1_nxt = v1;
      off0_nxt = '0;
      off1_nxt = '0;
      flag_nxt = no_inv;
    end else begin
      m00_nxt  = key_tl;
      m01_nxt  = key_tr;
      m10_nxt  = key_bl;
      m11_nxt  = key_br;
      vec0_nxt = p0_pipe_r[KEY_LAT-1];
      vec1_nxt = p1_pipe_r[KEY_LAT-1];
      off0_nxt = key_tl;
      off1_nxt = key_bl;
      flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m00_r        <= m00_nxt;
      m01_r        <= m01_nxt;
      m10_r        <= m10_nxt;
      m11_r        <= m11_nxt;
      vec0_r       <= vec0_nxt;
      vec1_r       <= vec1_nxt;
      off0_r       <= off0_nxt;
      off1_r       <= off1_nxt;
      flag_pipe_r  <= {flag_pipe_r[FLAG_N-2:0], flag_nxt};
      pr00_r       <= (2*RW)'(m00_r) * (2*RW)'(vec0_r);
      pr01_r       <= (2*RW)'(m01_r) * (2*RW)'(vec1_r);
      pr10_r       <= (2*RW)'(m10_r) * (2*RW)'(vec0_r);
      pr11_r       <= (2*RW)'(m11_r) * (2*RW)'(vec1_r);
      off0_d_r     <= off0_r;
      off1_d_r     <= off1_r;
      sum0_r       <= DW'(pr00_r) + DW'(pr01_r) + DW'(off0_d_r);
      sum1_r       <= DW'(pr10_r) + DW'(pr11_r) + DW'(off1_d_r);
      out_first_r  <= flag_pipe_r[FLAG_N-2] ? '0 : LETTER_W'(r0);
      out_second_r <= flag_pipe_r[FLAG_N-2] ? '0 : LETTER_W'(r1);
    end
  end

  ahc_modred #(.M(ALPHABET_SIZE), .W(DW), .RW(RW)) u_red_0 (
    .clk(clk), .en(en), .x(sum0_r), .r(r0)
  );
  ahc_modred #(.M(ALPHABET_SIZE), .W(DW), .RW(RW)) u_red_1 (
    .clk(clk), .en(en), .x(sum1_r), .r(r1)
  );

  assign out_res.valid      = vld_r[NS-1];
  assign out_res.out_first  = out_first_r;
  assign out_res.out_second = out_second_r;
  assign out_res.no_inverse = flag_pipe_r[FLAG_N-1];

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_pair.valid && in_pair.ready |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.no_inverse |->
      out_res.out_first == '0 && out_res.out_second == '0)
    else $error("singular key result carries nonzero letters");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |->
      out_res.out_first < ALPHABET_SIZE && out_res.out_second < ALPHABET_SIZE)
    else $error("result letter outside the alphabet");

endmodule

`default_nettype wire

>>> sim/affine_hill_cipher_2x2_test.sv
// Self-checking testbench for affine_hill_cipher_2x2: directed table, then random key phases.
// Predicts results in SystemVerilog or takes them from the table; compares field by field.
// Depends on ahc_pkg, ahc_ifs and the affine_hill_cipher_2x2 RTL.

module affine_hill_cipher_2x2_test;
  import ahc_pkg::*;

  localparam int unsigned LETTERS    = 26;
  localparam int unsigned LATENCY    = 18;
  localparam int unsigned N_DIR      = 38;
  localparam int unsigned N_PHASES   = 12;
  localparam int unsigned PHASE_REQS = 82;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    no_inverse;
  } cipher_res_t;

  typedef enum logic {ROW_PAIR, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    letter_t              first;
    letter_t              second;
    logic                 known;
    cipher_res_t          res;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  letter_t              cfg_wdata;

  ahc_in_if  in_ch();
  ahc_out_if out_ch();

  affine_hill_cipher_2x2 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pair   (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  letter_t     key_tl, key_tr, key_bl, key_br;
  logic        decrypt_on;
  cipher_res_t pending_results[$];
  int          errors = 0;
  int          stall_left = 0;
  bit          idle_en;

  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_PAIR,  '0,          5'd0,  5'd0,  1'b1, '{5'd3,  5'd2,  1'b0}},
    '{ROW_PAIR,  '0,          5'd25, 5'd25, 1'b1, '{5'd23, 5'd21, 1'b0}},
    '{ROW_PAIR,  '0,          5'd31, 5'd31, 1'b1, '{5'd7,  5'd11, 1'b0}},
    '{ROW_PAIR,  '0,          5'd26, 5'd13, 1'b0, '0},
    '{ROW_WRITE, CFG_DECRYPT, 5'd1,  5'd0,  1'b0, '0},
    '{ROW_PAIR,  '0,          5'd3,  5'd2,  1'b1, '{5'd0,  5'd0,  1'b0}},
    '{ROW_PAIR,  '0,          5'd23, 5'd21, 1'b1, '{5'd25, 5'd25, 1'b0}},
    '{ROW_PAIR,  '0,          5'd31, 5'd31, 1'b0, '0},
    '{ROW_PAIR,  '0,          5'd0,  5'd25, 1'b0, '0},
    '{ROW_WRITE, CFG_KEY_TL,  5'd2,  5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_TR,  5'd4,  5'd0,  1'b0, '0},
    '{ROW_PAIR,  '0,          5'd7,  5'd9,  1'b1, '{5'd0,  5'd0,  1'b1}},
    '{ROW_PAIR,  '0,          5'd31, 5'd0,  1'b1, '{5'd0,  5'd0,  1'b1}},
    '{ROW_WRITE, CFG_KEY_TL,  5'd1,  5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_TR,  5'd3,  5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_BL,  5'd2,  5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_BR,  5'd1,  5'd0,  1'b0, '0},
    '{ROW_PAIR,  '0,          5'd5,  5'd17, 1'b0, '0},
    '{ROW_PAIR,  '0,          5'd25, 5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_TL,  5'd27, 5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_TR,  5'd31, 5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_BL,  5'd30, 5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_BR,  5'd29, 5'd0,  1'b0, '0},
    '{ROW_PAIR,  '0,          5'd12, 5'd30, 1'b0, '0},
    '{ROW_WRITE, CFG_SPARE,   5'd0,  5'd0,  1'b0, '0},
    '{ROW_PAIR,  '0,          5'd1,  5'd1,  1'b0, '0},
    '{ROW_WRITE, CFG_DECRYPT, 5'd30, 5'd0,  1'b0, '0},
    '{ROW_PAIR,  '0,          5'd4,  5'd19, 1'b0, '0},
    '{ROW_WRITE, CFG_KEY_TL,  5'd0,  5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_TR,  5'd0,  5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_BL,  5'd0,  5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_BR,  5'd0,  5'd0,  1'b0, '0},
    '{ROW_PAIR,  '0,          5'd25, 5'd31, 1'b1, '{5'd0,  5'd0,  1'b0}},
    '{ROW_WRITE, CFG_DECRYPT, 5'd1,  5'd0,  1'b0, '0},
    '{ROW_PAIR,  '0,          5'd9,  5'd9,  1'b1, '{5'd0,  5'd0,  1'b1}},
    '{ROW_WRITE, CFG_KEY_TL,  5'd1,  5'd0,  1'b0, '0},
    '{ROW_WRITE, CFG_KEY_BR,  5'd1,  5'd0,  1'b0, '0},
    '{ROW_PAIR,  '0,          5'd0,  5'd0,  1'b1, '{5'd25, 5'd0,  1'b0}}
  };

  function automatic int unsigned det_inverse(int unsigned a, int unsigned b,
                                              int unsigned c, int unsigned d);
    int unsigned det;
    det = ((a % LETTERS) * (d % LETTERS) % LETTERS + LETTERS
           - (b % LETTERS) * (c % LETTERS) % LETTERS) % LETTERS;
    for (int unsigned x = 1; x < LETTERS; x++) begin
      if ((det * x) % LETTERS == 1) return x;
    end
    return 0;
  endfunction

  function automatic cipher_res_t cipher_pair(letter_t f, letter_t s);
    int unsigned a, b, c, d, p0, p1, dinv, v0, v1;
    cipher_res_t res;
    a    = key_tl % LETTERS;
    b    = key_tr % LETTERS;
    c    = key_bl % LETTERS;
    d    = key_br % LETTERS;
    p0   = f % LETTERS;
    p1   = s % LETTERS;
    res  = '0;
    if (!decrypt_on) begin
      res.first  = letter_t'((a * p0 + b * p1 + a) % LETTERS);
      res.second = letter_t'((c * p0 + d * p1 + c) % LETTERS);
    end else begin
      dinv = det_inverse(a, b, c, d);
      if (dinv == 0) begin
        res.no_inverse = 1'b1;
      end else begin
        v0 = (p0 + LETTERS - a) % LETTERS;
        v1 = (p1 + LETTERS - c) % LETTERS;
        res.first  = letter_t'((((d * dinv) % LETTERS) * v0
                               + (LETTERS - (b * dinv) % LETTERS) * v1) % LETTERS);
        res.second = letter_t'(((LETTERS - (c * dinv) % LETTERS) * v0
                               + ((a * dinv) % LETTERS) * v1) % LETTERS);
      end
    end
    return res;
  endfunction

  function automatic letter_t key_pick();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd25;
      2: return 5'd31;
      default: return letter_t'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic pause(input int unsigned n);
    in_ch.valid <= 1'b0;
    cfg_we      <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    if (pending_results.size() != 0) in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_pair(input letter_t f, input letter_t s, input cipher_res_t res);
    if (idle_en && $urandom_range(0, 5) == 0) pause($urandom_range(1, 9));
    in_ch.valid         <= 1'b1;
    in_ch.letter_first  <= f;
    in_ch.letter_second <= s;
    cfg_we              <= 1'b0;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(res);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input letter_t val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_KEY_TL:  key_tl     = val;
      CFG_KEY_TR:  key_tr     = val;
      CFG_KEY_BL:  key_bl     = val;
      CFG_KEY_BR:  key_br     = val;
      CFG_DECRYPT: decrypt_on = val[0];
      default: ;
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: first %0d second %0d no_inverse %0d", $time,
                   out_ch.out_first, out_ch.out_second, out_ch.no_inverse);
          errors++;
        end else begin
          cipher_res_t want;
          want = pending_results.pop_front();
          if (out_ch.out_first !== want.first) begin
            $display("%0t out_first: expected %0d, actual %0d", $time,
                     want.first, out_ch.out_first);
            errors++;
          end
          if (out_ch.out_second !== want.second) begin
            $display("%0t out_second: expected %0d, actual %0d", $time,
                     want.second, out_ch.out_second);
            errors++;
          end
          if (out_ch.no_inverse !== want.no_inverse) begin
            $display("%0t no_inverse: expected %0d, actual %0d", $time,
                     want.no_inverse, out_ch.no_inverse);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left   = $urandom_range(0, 8);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    letter_t     k[4];
    logic        mode;
    cipher_res_t want;
    idle_en             = 1'b1;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.letter_first  = '0;
    in_ch.letter_second = '0;
    key_tl              = 5'd3;
    key_tr              = 5'd3;
    key_bl              = 5'd2;
    key_br              = 5'd5;
    decrypt_on          = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_reg(dir_rows[i].reg_idx, dir_rows[i].first);
      end else begin
        want = dir_rows[i].known ? dir_rows[i].res
                                 : cipher_pair(dir_rows[i].first, dir_rows[i].second);
        send_pair(dir_rows[i].first, dir_rows[i].second, want);
      end
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain();
      idle_en = (phase < N_PHASES - 2) && (phase % 3 != 2);
      mode    = 1'($urandom_range(0, 1));
      // favor invertible keys when decrypting
      do begin
        foreach (k[j]) k[j] = key_pick();
      end while (mode && $urandom_range(0, 3) != 0
                 && det_inverse(k[0], k[1], k[2], k[3]) == 0);
      write_reg(CFG_KEY_TL, k[0]);
      write_reg(CFG_KEY_TR, k[1]);
      write_reg(CFG_KEY_BL, k[2]);
      write_reg(CFG_KEY_BR, k[3]);
      write_reg(CFG_DECRYPT, letter_t'(($urandom_range(0, 15) << 1) | mode));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, letter_t'($urandom_range(0, 31)));
      for (int n = 0; n < PHASE_REQS; n++) begin
        letter_t f, s;
        if (phase == 4 && n == PHASE_REQS / 2) drain();
        f = letter_t'($urandom_range(0, 31));
        s = letter_t'($urandom_range(0, 31));
        send_pair(f, s, cipher_pair(f, s));
      end
    end

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
